### rtl/assert_macros.svh
// Assertion helpers used by the datapath RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every edge out of reset.
`define MSC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Condition that must never be seen out of reset.
`define MSC_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

### rtl/mscpu_pkg.sv
// ----------------------------------------------------------------------------
// mscpu_pkg
// Types and codes of the microcoded stack CPU datapath.
// ----------------------------------------------------------------------------
package mscpu_pkg;

  localparam int CS_DEPTH = 512;
  localparam int CS_AW    = 9;

  // item kinds
  localparam logic [1:0] KIND_CS_LOAD  = 2'd0;
  localparam logic [1:0] KIND_MEM_LOAD = 2'd1;
  localparam logic [1:0] KIND_TICK     = 2'd2;

  // B bus sources
  localparam logic [3:0] BSEL_MDR  = 4'd0;
  localparam logic [3:0] BSEL_PC   = 4'd1;
  localparam logic [3:0] BSEL_MBRU = 4'd2;
  localparam logic [3:0] BSEL_MBRS = 4'd3;
  localparam logic [3:0] BSEL_SP   = 4'd4;
  localparam logic [3:0] BSEL_LV   = 4'd5;
  localparam logic [3:0] BSEL_CPP  = 4'd6;
  localparam logic [3:0] BSEL_TOS  = 4'd7;
  localparam logic [3:0] BSEL_OPC  = 4'd8;

  // memory operations
  localparam logic [2:0] MOP_FETCH = 3'd1;
  localparam logic [2:0] MOP_READ  = 3'd2;
  localparam logic [2:0] MOP_WRITE = 3'd4;

  // shifter
  localparam logic [1:0] SHF_SRL1 = 2'd1;
  localparam logic [1:0] SHF_SLL8 = 2'd2;

  // ALU functions
  localparam logic [5:0] ALU_AND      = 6'd12;
  localparam logic [5:0] ALU_ONE      = 6'd17;
  localparam logic [5:0] ALU_ONES     = 6'd18;
  localparam logic [5:0] ALU_B        = 6'd20;
  localparam logic [5:0] ALU_H        = 6'd24;
  localparam logic [5:0] ALU_NOT_H    = 6'd26;
  localparam logic [5:0] ALU_OR       = 6'd28;
  localparam logic [5:0] ALU_NOT_B    = 6'd44;
  localparam logic [5:0] ALU_INC_B    = 6'd53;
  localparam logic [5:0] ALU_DEC_B    = 6'd54;
  localparam logic [5:0] ALU_INC_H    = 6'd57;
  localparam logic [5:0] ALU_NEG_H    = 6'd59;
  localparam logic [5:0] ALU_ADD      = 6'd60;
  localparam logic [5:0] ALU_ADD_INC  = 6'd61;
  localparam logic [5:0] ALU_SUB      = 6'd63;

  // C bus write mask bits
  localparam int WR_MAR = 0;
  localparam int WR_MDR = 1;
  localparam int WR_PC  = 2;
  localparam int WR_SP  = 3;
  localparam int WR_LV  = 4;
  localparam int WR_CPP = 5;
  localparam int WR_TOS = 6;
  localparam int WR_OPC = 7;
  localparam int WR_H   = 8;

  // jump bits
  localparam int JMP_Z   = 0;
  localparam int JMP_N   = 1;
  localparam int JMP_MBR = 2;

  typedef struct packed {
    logic [8:0] next_addr;
    logic [2:0] jmp;
    logic [1:0] shift;
    logic [5:0] func;
    logic [8:0] wr_mask;
    logic [2:0] mop;
    logic [3:0] bsel;
  } ctl_word_t;

  typedef struct packed {
    logic [3:0] bsel;
    logic [5:0] func;
    logic [1:0] shift;
  } alu_ctl_t;

endpackage

### rtl/mscpu_alu.sv
// ----------------------------------------------------------------------------
// mscpu_alu
// B bus select, ALU and shifter of one microstep.
// ----------------------------------------------------------------------------
module mscpu_alu (
  input  mscpu_pkg::alu_ctl_t ctl,
  input  logic [31:0]         mdr,
  input  logic [31:0]         pc,
  input  logic [7:0]          mbr,
  input  logic [31:0]         sp,
  input  logic [31:0]         lv,
  input  logic [31:0]         cpp,
  input  logic [31:0]         tos,
  input  logic [31:0]         opc,
  input  logic [31:0]         h,
  input  logic [31:0]         c_hold,
  output logic [31:0]         c_out,
  output logic                zero
);
  import mscpu_pkg::*;

  logic [31:0] b_bus;
  logic [31:0] alu_res;

  always_comb begin
    case (ctl.bsel)
      BSEL_MDR:  b_bus = mdr;
      BSEL_PC:   b_bus = pc;
      BSEL_MBRU: b_bus = {24'd0, mbr};
      BSEL_MBRS: b_bus = {{24{mbr[7]}}, mbr};
      BSEL_SP:   b_bus = sp;
      BSEL_LV:   b_bus = lv;
      BSEL_CPP:  b_bus = cpp;
      BSEL_TOS:  b_bus = tos;
      BSEL_OPC:  b_bus = opc;
      default:   b_bus = '1;
    endcase
  end

  always_comb begin
    case (ctl.func)
      ALU_AND:     alu_res = h & b_bus;
      ALU_ONE:     alu_res = 32'd1;
      ALU_ONES:    alu_res = '1;
      ALU_B:       alu_res = b_bus;
      ALU_H:       alu_res = h;
      ALU_NOT_H:   alu_res = ~h;
      ALU_OR:      alu_res = h | b_bus;
      ALU_NOT_B:   alu_res = ~b_bus;
      ALU_INC_B:   alu_res = b_bus + 32'd1;
      ALU_DEC_B:   alu_res = b_bus - 32'd1;
      ALU_INC_H:   alu_res = h + 32'd1;
      ALU_NEG_H:   alu_res = 32'd0 - h;
      ALU_ADD:     alu_res = h + b_bus;
      ALU_ADD_INC: alu_res = h + b_bus + 32'd1;
      ALU_SUB:     alu_res = b_bus - h;
      default:     alu_res = c_hold;  // unlisted function repeats last C
    endcase
  end

  // zero flag is taken before the shifter
  assign zero = (alu_res == 32'd0);

  always_comb begin
    case (ctl.shift)
      SHF_SRL1: c_out = alu_res >> 1;
      SHF_SLL8: c_out = alu_res << 8;
      default:  c_out = alu_res;
    endcase
  end

endmodule

### rtl/microcoded_stack_cpu_datapath.sv
// ----------------------------------------------------------------------------
// microcoded_stack_cpu_datapath
// Microcoded stack CPU datapath: 512 x 36 control store, byte memory kept
// as 32-bit rows, three-stage pipe (control read, execute, memory return).
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | word
//  in_     | input     | in_valid / in_stall  | kind, index, load_value
//  out_    | output    | out_valid / out_stall| micro PC, zero flag, registers
//
//  Load items are taken every cycle while in_stall is low; a run item waits
//  in stage 1 until the run item ahead has done its control store read and
//  then the data memory read that feeds MBR and the next micro address.
//  out_valid rises once the item has passed stage 1, stage 2 and the output
//  register. After reset a clear pass zeroes both memories, with in_stall high. MEM_BYTES must be a power of two.
//  out_stall holds the output register; the pipe behind it fills, then
//  in_stall rises.
module microcoded_stack_cpu_datapath #(
  parameter int MEM_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [15:0] in_index,
  input  logic [35:0] in_load_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [8:0]  out_next_address,
  output logic        out_zero_flag,
  output logic [31:0] out_mar_value,
  output logic [31:0] out_mdr_value,
  output logic [31:0] out_pc_value,
  output logic [7:0]  out_mbr_value,
  output logic [31:0] out_sp_value,
  output logic [31:0] out_lv_value,
  output logic [31:0] out_cpp_value,
  output logic [31:0] out_tos_value,
  output logic [31:0] out_opc_value,
  output logic [31:0] out_h_value
);
  import mscpu_pkg::*;
  `include "assert_macros.svh"

  localparam int MEM_AW    = $clog2(MEM_BYTES);
  localparam int ROW_AW    = MEM_AW - 2;
  localparam int MEM_WORDS = MEM_BYTES / 4;
  localparam int CLR_N     = (MEM_WORDS > CS_DEPTH) ? MEM_WORDS : CS_DEPTH;
  localparam int CLR_W     = $clog2(CLR_N);

  // ---------------- memories ----------------
  logic [35:0] cs_mem [CS_DEPTH];
  logic [31:0] dmem [MEM_WORDS];

  logic [35:0]       cs_rdata_r;
  logic              cs_we;
  logic [CS_AW-1:0]  cs_waddr;
  logic [35:0]       cs_wdata;
  logic              cs_re;
  logic [CS_AW-1:0]  cs_raddr;

  logic [31:0]       mem_rdata_r;
  logic              mem_we;
  logic [3:0]        mem_be;
  logic [ROW_AW-1:0] mem_waddr;
  logic [31:0]       mem_wdata;
  logic              mem_re;
  logic [ROW_AW-1:0] mem_raddr;

  // ---------------- clear pass ----------------
  logic             clearing_r;
  logic [CLR_W-1:0] clr_cnt_r;

  // ---------------- architectural registers ----------------
  logic [8:0]  upc_r;
  logic        zero_r;
  logic [31:0] c_hold_r;
  logic [31:0] mar_r, mdr_r, pc_r, sp_r, lv_r, cpp_r, tos_r, opc_r, h_r;
  logic [7:0]  mbr_r;

  // ---------------- pipe stages ----------------
  logic              s1_valid_r;
  logic [1:0]        s1_kind_r;
  logic [MEM_AW-1:0] s1_addr_r;
  logic [7:0]        s1_byte_r;

  logic       s2_valid_r;
  logic       s2_tick_r;
  logic [2:0] s2_mop_r;
  logic [1:0] s2_boff_r;
  logic [8:0] s2_next_r;
  logic [2:0] s2_jmp_r;

  logic out_valid_r;

  // ---------------- handshake ----------------
  logic in_fire, in_tick, out_free, adv2, s1_tick, s1_fire, s1_open, s2_done;

  assign in_tick  = (in_kind == KIND_TICK);
  assign out_free = !out_valid_r || !out_stall;
  assign adv2     = !s2_valid_r || out_free;
  assign s2_done  = s2_valid_r && out_free;
  assign s1_tick  = (s1_kind_r == KIND_TICK);
  // a run item waits while the one ahead still owes MBR/MDR
  assign s1_fire  = s1_valid_r && adv2 && !(s1_tick && s2_valid_r && s2_tick_r);
  assign s1_open  = !s1_valid_r || s1_fire;
  assign in_stall = clearing_r || !s1_open || (in_tick && s1_valid_r && s1_tick);
  assign in_fire  = in_valid && !in_stall;

  // ---------------- stage 2 results ----------------
  logic [7:0]  fetch_byte;
  logic [7:0]  mbr_nxt;
  logic [31:0] mdr_nxt;
  logic [8:0]  upc_nxt;

  always_comb begin
    fetch_byte = mem_rdata_r[{s2_boff_r, 3'b000} +: 8];
    mbr_nxt = (s2_tick_r && s2_mop_r == MOP_FETCH) ? fetch_byte : mbr_r;
    mdr_nxt = (s2_tick_r && s2_mop_r == MOP_READ) ? mem_rdata_r : mdr_r;
    upc_nxt = s2_next_r;
    if (s2_jmp_r[JMP_Z])   upc_nxt[8] = upc_nxt[8] | zero_r;
    if (s2_jmp_r[JMP_N])   upc_nxt[8] = upc_nxt[8] | !zero_r;
    if (s2_jmp_r[JMP_MBR]) upc_nxt[7:0] = upc_nxt[7:0] | mbr_nxt;
  end

  // ---------------- stage 1 execute ----------------
  ctl_word_t   cw;
  alu_ctl_t    alu_ctl;
  logic [31:0] c_bus;
  logic        alu_zero;
  logic [31:0] mar_new, mdr_new, pc_new;

  assign cw      = ctl_word_t'(cs_rdata_r);
  assign alu_ctl = '{bsel: cw.bsel, func: cw.func, shift: cw.shift};

  mscpu_alu u_alu (
    .ctl    (alu_ctl),
    .mdr    (mdr_r),
    .pc     (pc_r),
    .mbr    (mbr_r),
    .sp     (sp_r),
    .lv     (lv_r),
    .cpp    (cpp_r),
    .tos    (tos_r),
    .opc    (opc_r),
    .h      (h_r),
    .c_hold (c_hold_r),
    .c_out  (c_bus),
    .zero   (alu_zero)
  );

  // memory ops see the registers after this step's C write
  assign mar_new = cw.wr_mask[WR_MAR] ? c_bus : mar_r;
  assign mdr_new = cw.wr_mask[WR_MDR] ? c_bus : mdr_r;
  assign pc_new  = cw.wr_mask[WR_PC]  ? c_bus : pc_r;

  // ---------------- memory port control ----------------
  logic [31:0] idx_ext;
  logic        clr_cs, clr_mem;

  assign idx_ext = {16'd0, in_index};
  assign clr_cs  = ({1'b0, clr_cnt_r} < (CLR_W + 1)'(CS_DEPTH));
  assign clr_mem = ({1'b0, clr_cnt_r} < (CLR_W + 1)'(MEM_WORDS));

  always_comb begin
    cs_we    = 1'b0;
    cs_waddr = in_index[CS_AW-1:0];
    cs_wdata = in_load_value;
    if (clearing_r) begin
      cs_we    = clr_cs;
      cs_waddr = clr_cnt_r[CS_AW-1:0];
      cs_wdata = '0;
    end else if (in_fire && in_kind == KIND_CS_LOAD) begin
      cs_we = 1'b1;
    end
    cs_re    = in_fire && in_tick;
    // forward the next micro address of a run item still in stage 2
    cs_raddr = (s2_valid_r && s2_tick_r) ? upc_nxt : upc_r;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_be    = 4'b1111;
    mem_waddr = mar_new[ROW_AW-1:0];
    mem_wdata = mdr_new;
    mem_re    = 1'b0;
    mem_raddr = mar_new[ROW_AW-1:0];
    if (clearing_r) begin
      mem_we    = clr_mem;
      mem_waddr = clr_cnt_r[ROW_AW-1:0];
      mem_wdata = '0;
    end else if (s1_fire && s1_kind_r == KIND_MEM_LOAD) begin
      mem_we    = 1'b1;
      mem_be    = 4'b0001 << s1_addr_r[1:0];
      mem_waddr = s1_addr_r[MEM_AW-1:2];
      mem_wdata = {4{s1_byte_r}};
    end else if (s1_fire && s1_tick) begin
      mem_we = (cw.mop == MOP_WRITE);
      mem_re = (cw.mop == MOP_FETCH) || (cw.mop == MOP_READ);
      if (cw.mop == MOP_FETCH) begin
        mem_raddr = pc_new[MEM_AW-1:2];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cs_we) begin
      cs_mem[cs_waddr] <= cs_wdata;
    end
    if (cs_re) begin
      cs_rdata_r <= cs_mem[cs_raddr];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      if (mem_we && mem_be[i]) begin
        dmem[mem_waddr][8*i +: 8] <= mem_wdata[8*i +: 8];
      end
    end
    if (mem_re) begin
      mem_rdata_r <= dmem[mem_raddr];
    end
  end

  // ---------------- control state ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r  <= 1'b1;
      clr_cnt_r   <= '0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s2_tick_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (clearing_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == CLR_W'(CLR_N - 1)) begin
          clearing_r <= 1'b0;
        end
      end
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (adv2) begin
        s2_valid_r <= s1_fire;
        s2_tick_r  <= s1_fire && s1_tick;
      end
      if (s2_done) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_kind_r <= in_kind;
      s1_addr_r <= idx_ext[MEM_AW-1:0];
      s1_byte_r <= in_load_value[7:0];
    end
    if (s1_fire) begin
      s2_mop_r  <= s1_tick ? cw.mop : 3'b000;
      s2_boff_r <= pc_new[1:0];
      s2_next_r <= cw.next_addr;
      s2_jmp_r  <= s1_tick ? cw.jmp : 3'b000;
    end
    if (s2_done) begin
      out_next_address <= s2_tick_r ? upc_nxt : upc_r;
      out_zero_flag    <= zero_r;
      out_mar_value    <= mar_r;
      out_mdr_value    <= mdr_nxt;
      out_pc_value     <= pc_r;
      out_mbr_value    <= mbr_nxt;
      out_sp_value     <= sp_r;
      out_lv_value     <= lv_r;
      out_cpp_value    <= cpp_r;
      out_tos_value    <= tos_r;
      out_opc_value    <= opc_r;
      out_h_value      <= h_r;
    end
  end

  // ---------------- architectural registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r    <= '0;
      zero_r   <= 1'b0;
      c_hold_r <= '0;
      mar_r    <= '0;
      mdr_r    <= '0;
      pc_r     <= '0;
      mbr_r    <= '0;
      sp_r     <= '0;
      lv_r     <= '0;
      cpp_r    <= '0;
      tos_r    <= '0;
      opc_r    <= '0;
      h_r      <= '0;
    end else begin
      if (s1_fire && s1_tick) begin
        zero_r   <= alu_zero;
        c_hold_r <= c_bus;
        mar_r    <= mar_new;
        pc_r     <= pc_new;
        mdr_r    <= mdr_new;
        if (cw.wr_mask[WR_SP])  sp_r  <= c_bus;
        if (cw.wr_mask[WR_LV])  lv_r  <= c_bus;
        if (cw.wr_mask[WR_CPP]) cpp_r <= c_bus;
        if (cw.wr_mask[WR_TOS]) tos_r <= c_bus;
        if (cw.wr_mask[WR_OPC]) opc_r <= c_bus;
        if (cw.wr_mask[WR_H])   h_r   <= c_bus;
      end
      if (s2_done && s2_tick_r) begin
        upc_r <= upc_nxt;
        mbr_r <= mbr_nxt;
        mdr_r <= mdr_nxt;
      end
    end
  end

  assign out_valid = out_valid_r;

  // ---------------- assertions ----------------
  `MSC_NEVER(a_no_accept_in_clear, clk, rst_n, clearing_r && in_fire, "word taken during clear")
  `MSC_NEVER(a_tick_overlap, clk, rst_n, s1_fire && s1_tick && s2_valid_r && s2_tick_r, "run overlap")
  `MSC_ASSERT(a_s1_moves, clk, rst_n, s1_fire |=> s2_valid_r, "stage 1 word lost")
  `MSC_ASSERT(a_s2_moves, clk, rst_n, s2_done |=> out_valid, "stage 2 word lost")

endmodule

### tb/tb_microcoded_stack_cpu_datapath.sv
// ----------------------------------------------------------------------------
// tb_microcoded_stack_cpu_datapath
// Self-checking bench for the microcoded stack datapath. A directed
// microprogram exercises the corner cases. Random control words are then
// written at the live micro PC and run, mixed with memory byte loads where
// the next fetch or word access will look, plus stray loads and unused
// kinds. Each output word is compared with a local model of the datapath.
// Both sides idle at random, and the receiver holds off once for a long
// stretch.
// ----------------------------------------------------------------------------
module tb_microcoded_stack_cpu_datapath;
  timeunit 1ns;
  timeprecision 1ps;

  import mscpu_pkg::*;

  localparam int RAM_BYTES   = 65536;
  localparam int N_WORDS     = 650;
  localparam int HOLD_AT     = 120;
  localparam int HOLD_CYCLES = 100;
  localparam int DRAIN       = 20;
  localparam int LIMIT       = 300000;
  localparam int MAX_REPORTS = 200;

  // codes the package leaves unnamed
  localparam logic [1:0] KIND_NONE  = 2'd3;
  localparam logic [3:0] BSEL_NONE  = 4'd15;
  localparam logic [2:0] MOP_IDLE   = 3'd0;
  localparam logic [2:0] MOP_ODD    = 3'd7;
  localparam logic [1:0] SHF_NONE   = 2'd0;
  localparam logic [1:0] SHF_RSV    = 2'd3;
  localparam logic [5:0] ALU_UNUSED = 6'd0;

  typedef struct packed {
    logic [8:0]  upc;
    logic        zf;
    logic [31:0] mar, mdr, pc;
    logic [7:0]  mbr;
    logic [31:0] sp, lv, cpp, tos, opc, h;
  } snap_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] index;
    logic [35:0] value;
    snap_t       want;
  } item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_kind = '0;
  logic [15:0] in_index = '0;
  logic [35:0] in_load_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [8:0]  out_next_address;
  logic        out_zero_flag;
  logic [31:0] out_mar_value, out_mdr_value, out_pc_value;
  logic [7:0]  out_mbr_value;
  logic [31:0] out_sp_value, out_lv_value, out_cpp_value;
  logic [31:0] out_tos_value, out_opc_value, out_h_value;

  microcoded_stack_cpu_datapath #(.MEM_BYTES(RAM_BYTES)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_index         (in_index),
    .in_load_value    (in_load_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_next_address (out_next_address),
    .out_zero_flag    (out_zero_flag),
    .out_mar_value    (out_mar_value),
    .out_mdr_value    (out_mdr_value),
    .out_pc_value     (out_pc_value),
    .out_mbr_value    (out_mbr_value),
    .out_sp_value     (out_sp_value),
    .out_lv_value     (out_lv_value),
    .out_cpp_value    (out_cpp_value),
    .out_tos_value    (out_tos_value),
    .out_opc_value    (out_opc_value),
    .out_h_value      (out_h_value)
  );

  initial forever #6 clk = ~clk;

  // ---------------- datapath model ----------------
  logic [35:0] ucode [CS_DEPTH];
  logic [7:0]  ram [RAM_BYTES];
  logic [8:0]  upc;
  logic [31:0] mar_r, mdr_r, pc_r, sp_r, lv_r, cpp_r, tos_r, opc_r, h_r, c_latch;
  logic [7:0]  mbr_r;
  logic        zf;

  logic [5:0] alu_list [15] = '{ALU_AND, ALU_ONE, ALU_ONES, ALU_B, ALU_H, ALU_NOT_H,
                                ALU_OR, ALU_NOT_B, ALU_INC_B, ALU_DEC_B, ALU_INC_H,
                                ALU_NEG_H, ALU_ADD, ALU_ADD_INC, ALU_SUB};
  logic [2:0] mop_list [4] = '{MOP_IDLE, MOP_FETCH, MOP_READ, MOP_WRITE};

  function automatic int unsigned ram_addr(logic [33:0] a);
    return int'(a % RAM_BYTES);
  endfunction

  function automatic logic [31:0] bus_b(logic [3:0] sel);
    case (sel)
      BSEL_MDR:  return mdr_r;
      BSEL_PC:   return pc_r;
      BSEL_MBRU: return {24'd0, mbr_r};
      BSEL_MBRS: return {{24{mbr_r[7]}}, mbr_r};
      BSEL_SP:   return sp_r;
      BSEL_LV:   return lv_r;
      BSEL_CPP:  return cpp_r;
      BSEL_TOS:  return tos_r;
      BSEL_OPC:  return opc_r;
      default:   return '1;
    endcase
  endfunction

  function automatic logic [31:0] alu_out(logic [5:0] f, logic [31:0] b);
    case (f)
      ALU_AND:     return h_r & b;
      ALU_ONE:     return 32'd1;
      ALU_ONES:    return '1;
      ALU_B:       return b;
      ALU_H:       return h_r;
      ALU_NOT_H:   return ~h_r;
      ALU_OR:      return h_r | b;
      ALU_NOT_B:   return ~b;
      ALU_INC_B:   return b + 32'd1;
      ALU_DEC_B:   return b - 32'd1;
      ALU_INC_H:   return h_r + 32'd1;
      ALU_NEG_H:   return 32'd0 - h_r;
      ALU_ADD:     return h_r + b;
      ALU_ADD_INC: return h_r + b + 32'd1;
      ALU_SUB:     return b - h_r;
      default:     return c_latch;  // unlisted code replays the last C value
    endcase
  endfunction

  // Apply one input word to the model, return the register snapshot after it.
  function automatic snap_t step_datapath(logic [1:0] kind, logic [15:0] index,
                                          logic [35:0] value);
    ctl_word_t   cw;
    logic [31:0] c;
    logic [8:0]  nxt;
    case (kind)
      KIND_CS_LOAD:  ucode[index[CS_AW-1:0]] = value;
      KIND_MEM_LOAD: ram[ram_addr(34'(index))] = value[7:0];
      KIND_TICK: begin
        cw = ctl_word_t'(ucode[upc]);
        c = alu_out(cw.func, bus_b(cw.bsel));
        zf = (c == 32'd0);  // flag is taken before the shifter
        case (cw.shift)
          SHF_SRL1: c = c >> 1;
          SHF_SLL8: c = c << 8;
          default: ;
        endcase
        c_latch = c;
        if (cw.wr_mask[WR_MAR]) mar_r = c;
        if (cw.wr_mask[WR_MDR]) mdr_r = c;
        if (cw.wr_mask[WR_PC])  pc_r  = c;
        if (cw.wr_mask[WR_SP])  sp_r  = c;
        if (cw.wr_mask[WR_LV])  lv_r  = c;
        if (cw.wr_mask[WR_CPP]) cpp_r = c;
        if (cw.wr_mask[WR_TOS]) tos_r = c;
        if (cw.wr_mask[WR_OPC]) opc_r = c;
        if (cw.wr_mask[WR_H])   h_r   = c;
        case (cw.mop)
          MOP_FETCH: mbr_r = ram[ram_addr(34'(pc_r))];
          MOP_READ:
            for (int k = 0; k < 4; k++)
              mdr_r[8*k +: 8] = ram[ram_addr({mar_r, 2'b00} + 34'(k))];
          MOP_WRITE:
            for (int k = 0; k < 4; k++)
              ram[ram_addr({mar_r, 2'b00} + 34'(k))] = mdr_r[8*k +: 8];
          default: ;
        endcase
        nxt = cw.next_addr;
        if (cw.jmp[JMP_Z])   nxt[8] = nxt[8] | zf;
        if (cw.jmp[JMP_N])   nxt[8] = nxt[8] | !zf;
        if (cw.jmp[JMP_MBR]) nxt[7:0] = nxt[7:0] | mbr_r;
        upc = nxt;
      end
      default: ;
    endcase
    return '{upc, zf, mar_r, mdr_r, pc_r, mbr_r, sp_r, lv_r, cpp_r, tos_r, opc_r, h_r};
  endfunction

  // ---------------- stimulus ----------------
  item_t items_to_send [$];
  snap_t snapshots_due [$];
  int n_words = 0, n_ticks = 0, n_cs = 0, n_mem = 0, n_odd = 0;

  function automatic void queue_word(logic [1:0] kind, logic [15:0] index,
                                     logic [35:0] value);
    item_t it;
    it.kind  = kind;
    it.index = index;
    it.value = value;
    it.want  = step_datapath(kind, index, value);
    items_to_send.push_back(it);
    n_words++;
    case (kind)
      KIND_TICK:     n_ticks++;
      KIND_CS_LOAD:  n_cs++;
      KIND_MEM_LOAD: n_mem++;
      default:       n_odd++;
    endcase
  endfunction

  function automatic logic [35:0] mk_ctl(logic [8:0] nxt, logic [2:0] jmp,
                                         logic [1:0] shf, logic [5:0] func,
                                         logic [8:0] mask, logic [2:0] mop,
                                         logic [3:0] bsel);
    ctl_word_t cw;
    cw = '{next_addr: nxt, jmp: jmp, shift: shf, func: func, wr_mask: mask,
           mop: mop, bsel: bsel};
    return 36'(cw);
  endfunction

  // mostly legal fields; the rest stays fully random
  function automatic logic [35:0] random_ucode();
    ctl_word_t cw;
    cw = ctl_word_t'({$urandom, 4'($urandom)});
    if ($urandom_range(0, 9) != 0) cw.bsel = 4'($urandom_range(0, 8));
    if ($urandom_range(0, 9) != 0) cw.func = alu_list[$urandom_range(0, 14)];
    if ($urandom_range(0, 3) != 0) cw.mop = mop_list[$urandom_range(0, 3)];
    return 36'(cw);
  endfunction

  function automatic logic [35:0] rand36();
    return {4'($urandom), 32'($urandom)};
  endfunction

  function automatic void build_stimulus();
    int unsigned r;
    logic [15:0] idx;
    foreach (ucode[i]) ucode[i] = '0;
    foreach (ram[i]) ram[i] = '0;
    upc = '0;
    {mar_r, mdr_r, pc_r, sp_r, lv_r, cpp_r, tos_r, opc_r, h_r, c_latch} = '0;
    mbr_r = '0;
    zf = 1'b0;

    // directed microprogram: wrap of indices and addresses, sign extension,
    // held C value, flag jumps and MBR jump, odd B select / mop / shift
    queue_word(KIND_MEM_LOAD, 16'hFFFF, 36'hF_FFFF_FF80);
    queue_word(KIND_MEM_LOAD, 16'hFFFC, 36'h0_0000_00FF);
    queue_word(KIND_MEM_LOAD, 16'h0000, 36'h0);
    queue_word(KIND_CS_LOAD, 16'hFE00,
               mk_ctl(9'd1, 3'd0, SHF_NONE, ALU_ONES, 9'(1 << WR_H), MOP_IDLE, BSEL_MDR));
    queue_word(KIND_CS_LOAD, 16'd1,
               mk_ctl(9'd2, 3'd0, SHF_NONE, ALU_H, 9'((1 << WR_PC) | (1 << WR_MAR)),
                      MOP_FETCH, BSEL_MDR));
    queue_word(KIND_CS_LOAD, 16'd2,
               mk_ctl(9'd3, 3'd0, SHF_NONE, ALU_B, 9'(1 << WR_TOS), MOP_READ, BSEL_MBRS));
    queue_word(KIND_CS_LOAD, 16'd3,
               mk_ctl(9'd3, 3'((1 << JMP_N) | (1 << JMP_MBR)), SHF_SLL8, ALU_UNUSED,
                      9'(1 << WR_SP), MOP_WRITE, BSEL_PC));
    queue_word(KIND_CS_LOAD, 16'h0183,
               mk_ctl(9'd0, 3'(1 << JMP_Z), SHF_SRL1, ALU_INC_B, 9'(1 << WR_OPC),
                      MOP_IDLE, BSEL_NONE));
    queue_word(KIND_CS_LOAD, 16'h0100,
               mk_ctl(9'h1FF, 3'd0, SHF_RSV, ALU_SUB, '1, MOP_ODD, BSEL_OPC));
    queue_word(KIND_CS_LOAD, 16'hFFFF,
               mk_ctl(9'd4, 3'd0, SHF_NONE, ALU_NEG_H, 9'(1 << WR_LV), MOP_READ, BSEL_LV));
    queue_word(KIND_CS_LOAD, 16'd4,
               mk_ctl(9'd0, 3'(1 << JMP_MBR), SHF_NONE, ALU_ADD_INC,
                      9'((1 << WR_CPP) | (1 << WR_H)), MOP_FETCH, BSEL_MBRU));
    for (int i = 0; i < 9; i++) queue_word(KIND_TICK, 16'hFFFF, '1);
    queue_word(KIND_NONE, 16'hFFFF, '1);
    queue_word(KIND_TICK, 16'h0000, '0);

    // random part: mostly a fresh control word at the live micro PC, then run
    while (n_words < N_WORDS) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        queue_word(KIND_CS_LOAD, {7'($urandom), upc}, random_ucode());
        queue_word(KIND_TICK, 16'($urandom), rand36());
      end else if (r < 68) begin
        queue_word(KIND_TICK, 16'($urandom), rand36());
      end else if (r < 84) begin
        // seed the byte the next fetch or word access will touch
        if ($urandom_range(0, 1) != 0) idx = 16'(ram_addr(34'(pc_r)));
        else idx = 16'(ram_addr({mar_r, 2'b00} + 34'($urandom_range(0, 3))));
        queue_word(KIND_MEM_LOAD, idx, rand36());
      end else if (r < 92) begin
        queue_word(KIND_CS_LOAD, 16'($urandom), rand36());
      end else if (r < 98) begin
        queue_word(KIND_MEM_LOAD, 16'($urandom), rand36());
      end else begin
        queue_word(KIND_NONE, 16'($urandom), rand36());
      end
    end
  endfunction

  // ---------------- driver ----------------
  int n_sent = 0;
  int unsigned src_wait = 0;
  bit src_calm = 1'b0;
  item_t cur;

  always @(posedge clk) begin
    logic offering;
    if (!rst_n) begin
      in_valid <= 1'b0;
      src_wait <= 0;
    end else begin
      offering = in_valid;
      if (in_valid && !in_stall) begin
        snapshots_due.push_back(cur.want);
        n_sent <= n_sent + 1;
        offering = 1'b0;
      end
      if (!offering) begin
        if (src_wait != 0) begin
          src_wait <= src_wait - 1;
        end else if (items_to_send.size() != 0) begin
          cur = items_to_send.pop_front();
          in_kind       <= cur.kind;
          in_index      <= cur.index;
          in_load_value <= cur.value;
          offering = 1'b1;
          if ($urandom_range(0, 49) == 0) src_calm = !src_calm;
          src_wait <= src_calm ? 0 : $urandom_range(0, 6);
        end
      end
      in_valid <= offering;
    end
  end

  // ---------------- monitor ----------------
  int n_rcv = 0;
  int n_err = 0;
  int unsigned snk_wait = 0;
  bit snk_calm = 1'b0;
  int hold_cnt = 0;
  logic holding;

  assign holding = (n_rcv >= HOLD_AT) && (hold_cnt < HOLD_CYCLES);

  // one long hold-off so the pipe fills and the input side backs up
  always @(posedge clk) begin
    if (rst_n && holding) hold_cnt <= hold_cnt + 1;
  end

  task automatic compare_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      if (n_err < MAX_REPORTS)
        $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
      n_err++;
    end
  endtask

  always @(posedge clk) begin
    int unsigned pause;
    snap_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      snk_wait  <= 0;
    end else begin
      pause = snk_wait;
      if (out_valid && !out_stall) begin
        n_rcv <= n_rcv + 1;
        if (snapshots_due.size() == 0) begin
          $display("%0t: output word with nothing pending, expected none, got upc %h",
                   $time, out_next_address);
          n_err++;
        end else begin
          want = snapshots_due.pop_front();
          compare_field("next_address", 32'(want.upc), 32'(out_next_address));
          compare_field("zero_flag", 32'(want.zf), 32'(out_zero_flag));
          compare_field("mar", want.mar, out_mar_value);
          compare_field("mdr", want.mdr, out_mdr_value);
          compare_field("pc", want.pc, out_pc_value);
          compare_field("mbr", 32'(want.mbr), 32'(out_mbr_value));
          compare_field("sp", want.sp, out_sp_value);
          compare_field("lv", want.lv, out_lv_value);
          compare_field("cpp", want.cpp, out_cpp_value);
          compare_field("tos", want.tos, out_tos_value);
          compare_field("opc", want.opc, out_opc_value);
          compare_field("h", want.h, out_h_value);
        end
        if ($urandom_range(0, 49) == 0) snk_calm = !snk_calm;
        pause = snk_calm ? 0 : $urandom_range(0, 6);
      end else if (pause != 0) begin
        pause--;
      end
      snk_wait  <= pause;
      out_stall <= (pause != 0) || holding;
    end
  end

  // ---------------- watchdog ----------------
  int cycles = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d of %0d words sent, %0d pending",
               cycles, n_sent, n_words, snapshots_due.size());
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------- sequence ----------------
  initial begin
    build_stimulus();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    // the block clears its stores after reset with in_stall high
    while (n_sent < n_words || snapshots_due.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    $display("ran %0d microsteps with %0d control word loads, %0d memory byte loads",
             n_ticks, n_cs, n_mem);
    $display("and %0d unused-kind words; one receiver hold-off of %0d cycles",
             n_odd, HOLD_CYCLES);
    if (n_err == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", n_err);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
